// ===== hw/rtl/wrrg_pkg.sv =====
// shared types and constants for the whitened random range generator
// no dependencies; imported by every module of the block
package wrrg_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int VALUE_BITS  = 32;
   localparam int LEFT_BITS   = 5;
   localparam int INDEX_BITS  = 2;

   typedef enum logic [1:0] {
      MODE_BYTE  = 2'd0,
      MODE_W15   = 2'd1,
      MODE_W31   = 2'd2,
      MODE_RANGE = 2'd3
   } out_mode_type;

   localparam logic [INDEX_BITS-1:0] CSR_OUT_MODE   = 2'd0;
   localparam logic [INDEX_BITS-1:0] CSR_RANGE_LOW  = 2'd1;
   localparam logic [INDEX_BITS-1:0] CSR_RANGE_HIGH = 2'd2;

   localparam logic [LEFT_BITS-1:0] LEFT_BYTE = 5'd8;
   localparam logic [LEFT_BITS-1:0] LEFT_W15  = 5'd15;
   localparam logic [LEFT_BITS-1:0] LEFT_W31  = 5'd31;

   // configuration as seen by the value builder
   typedef struct packed {
      out_mode_type            mode;
      logic [VALUE_BITS-1:0]   low;
      logic [VALUE_BITS-1:0]   span;
      logic [VALUE_BITS-1:0]   top;
      logic                    span_le1;
   } cfg_view_type;

endpackage

// ===== hw/rtl/whitened_random_range_generator_top.sv =====
// top level of the whitened random range generator: input and result registers
// depends on wrrg_pkg, wrrg_cfg, wrrg_whiten, wrrg_build
//
//   channel  | ports            | word
//   ---------+------------------+--------------------------------------
//   input    | req_t*           | tdata[11:0] adc_sample, [15:12] zero
//   result   | rsp_t*           | tdata[31:0] rand_value
//   config   | csr_wen/index/wd | index 0 out_mode, 1 range_low, 2 range_high
//
// one word accepted per cycle unless stalled; a taken word is held in the input register
// until evaluated, and its result, if any, is registered at the end of its evaluation cycle.
// after reset and after each config write to index 0, 1 or 2 req_tready stays low
// while the span and its top-bit mask are registered.
// a full result register that is not taken stalls evaluation and input.
// reset is synchronous and clears the whitening and builder state.
module whitened_random_range_generator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // [11:0] adc_sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,  // [31:0] rand_value
   input  logic                                csr_wen,
   input  logic [wrrg_pkg::INDEX_BITS-1:0]     csr_index,
   input  logic [wrrg_pkg::VALUE_BITS-1:0]     csr_wdata
);
   import wrrg_pkg::*;

   cfg_view_type            cfg;
   logic                    cfg_abort;
   logic                    cfg_settled;
   logic                    in_valid_ff, in_valid_in;
   logic                    in_bit_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0]   out_data_ff;
   logic                    go;
   logic                    bypass;
   logic                    white_valid;
   logic                    white_bit;
   logic                    res_valid;
   logic [VALUE_BITS-1:0]   res_value;
   logic                    req_take;

   wrrg_cfg u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg),
      .cfg_abort   (cfg_abort),
      .cfg_settled (cfg_settled)
   );

   assign go         = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = cfg_settled && (!in_valid_ff || go);
   assign req_take   = req_tvalid && req_tready;

   // the bypassed word never reaches the whitening stages
   wrrg_whiten u_whiten (
      .clock       (clock),
      .reset       (reset),
      .raw_en      (go && !bypass),
      .raw_bit     (in_bit_ff),
      .white_valid (white_valid),
      .white_bit   (white_bit)
   );

   wrrg_build u_build (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cfg_abort   (cfg_abort),
      .go          (go),
      .white_valid (white_valid),
      .white_bit   (white_bit),
      .bypass      (bypass),
      .res_valid   (res_valid),
      .res_value   (res_value)
   );

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (go && res_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_bit_ff <= req_tdata[0];
      end
      if (go && res_valid) begin
         out_data_ff <= res_value;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== hw/rtl/wrrg_cfg.sv =====
// configuration registers plus registered span and top-bit mask
// depends on wrrg_pkg
module wrrg_cfg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [wrrg_pkg::INDEX_BITS-1:0]      csr_index,
   input  logic [wrrg_pkg::VALUE_BITS-1:0]      csr_wdata,
   output wrrg_pkg::cfg_view_type               cfg,
   output logic                                 cfg_abort,
   output logic                                 cfg_settled
);
   import wrrg_pkg::*;

   out_mode_type            mode_ff, mode_in;
   logic [VALUE_BITS-1:0]   low_ff, low_in;
   logic [VALUE_BITS-1:0]   high_ff, high_in;
   logic [VALUE_BITS-1:0]   span_ff, span_in;
   logic [VALUE_BITS-1:0]   top_ff, top_in;
   logic                    le1_ff, le1_in;
   logic [1:0]              settle_ff, settle_in;
   logic [VALUE_BITS-1:0]   smear;

   always_comb begin
      mode_in   = mode_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      cfg_abort = 1'b0;
      if (csr_wen) begin
         case (csr_index)
            CSR_OUT_MODE: begin
               mode_in   = out_mode_type'(csr_wdata[1:0]);
               cfg_abort = 1'b1;
            end
            CSR_RANGE_LOW: begin
               low_in    = csr_wdata;
               cfg_abort = 1'b1;
            end
            CSR_RANGE_HIGH: begin
               high_in   = csr_wdata;
               cfg_abort = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // span_ff is registered from the bound registers, and top_ff from span_ff
   always_comb begin
      span_in = (high_ff > low_ff) ? (high_ff - low_ff) : '0;
      smear   = span_ff - VALUE_BITS'(1);
      smear   = smear | (smear >> 1);
      smear   = smear | (smear >> 2);
      smear   = smear | (smear >> 4);
      smear   = smear | (smear >> 8);
      smear   = smear | (smear >> 16);
      top_in  = smear ^ (smear >> 1);
      le1_in  = (span_ff <= VALUE_BITS'(1));
   end

   always_comb begin
      if (cfg_abort) begin
         settle_in = 2'd2;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_BYTE;
         low_ff    <= '0;
         high_ff   <= '0;
         span_ff   <= '0;
         top_ff    <= '0;
         le1_ff    <= 1'b1;
         settle_ff <= 2'd2;
      end else begin
         mode_ff   <= mode_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
         span_ff   <= span_in;
         top_ff    <= top_in;
         le1_ff    <= le1_in;
         settle_ff <= settle_in;
      end
   end

   assign cfg.mode     = mode_ff;
   assign cfg.low      = low_ff;
   assign cfg.span     = span_ff;
   assign cfg.top      = top_ff;
   assign cfg.span_le1 = le1_ff;
   assign cfg_settled  = (settle_ff == 2'd0);

endmodule

// ===== hw/rtl/wrrg_whiten.sv =====
// two cascaded von neumann stages on the sample's low bit
// depends on wrrg_pkg
module wrrg_whiten (
   input  logic clock,
   input  logic reset,
   input  logic raw_en,
   input  logic raw_bit,
   output logic white_valid,
   output logic white_bit
);
   import wrrg_pkg::*;

   logic first1_ff, first1_in;
   logic have1_ff, have1_in;
   logic first2_ff, first2_in;
   logic have2_ff, have2_in;
   logic b1_valid;

   always_comb begin
      first1_in   = first1_ff;
      have1_in    = have1_ff;
      first2_in   = first2_ff;
      have2_in    = have2_ff;
      b1_valid    = 1'b0;
      white_valid = 1'b0;
      white_bit   = raw_bit;
      if (raw_en) begin
         if (!have1_ff) begin
            first1_in = raw_bit;
            have1_in  = 1'b1;
         end else begin
            have1_in = 1'b0;
            b1_valid = (first1_ff != raw_bit);
         end
      end
      // stage one emits the second bit of its pair
      if (b1_valid) begin
         if (!have2_ff) begin
            first2_in = raw_bit;
            have2_in  = 1'b1;
         end else begin
            have2_in    = 1'b0;
            white_valid = (first2_ff != raw_bit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first1_ff <= 1'b0;
         have1_ff  <= 1'b0;
         first2_ff <= 1'b0;
         have2_ff  <= 1'b0;
      end else begin
         first1_ff <= first1_in;
         have1_ff  <= have1_in;
         first2_ff <= first2_in;
         have2_ff  <= have2_in;
      end
   end

endmodule

// ===== hw/rtl/wrrg_build.sv =====
// value builder: fixed-width shift accumulator and bounded range builder
// depends on wrrg_pkg
module wrrg_build (
   input  logic                              clock,
   input  logic                              reset,
   input  wrrg_pkg::cfg_view_type            cfg,
   input  logic                              cfg_abort,
   input  logic                              go,
   input  logic                              white_valid,
   input  logic                              white_bit,
   output logic                              bypass,
   output logic                              res_valid,
   output logic [wrrg_pkg::VALUE_BITS-1:0]   res_value
);
   import wrrg_pkg::*;

   logic [VALUE_BITS-1:0] accum_ff, accum_in;
   logic [VALUE_BITS-1:0] mask_ff, mask_in;
   logic [LEFT_BITS-1:0]  left_ff, left_in;
   logic                  started_ff, started_in;
   logic                  done;

   assign bypass = !started_ff && (cfg.mode == MODE_RANGE) && cfg.span_le1;

   always_comb begin
      accum_in   = accum_ff;
      mask_in    = mask_ff;
      left_in    = left_ff;
      started_in = started_ff;
      res_valid  = 1'b0;
      res_value  = '0;
      done       = 1'b0;
      if (go) begin
         if (bypass) begin
            res_valid = 1'b1;
            res_value = cfg.low;
         end else begin
            if (!started_ff) begin
               started_in = 1'b1;
               accum_in   = '0;
               mask_in    = '0;
               left_in    = '0;
               case (cfg.mode)
                  MODE_BYTE:  left_in = LEFT_BYTE;
                  MODE_W15:   left_in = LEFT_W15;
                  MODE_W31:   left_in = LEFT_W31;
                  MODE_RANGE: mask_in = cfg.top;
                  default:    ;
               endcase
            end
            if (white_valid) begin
               if (cfg.mode == MODE_RANGE) begin
                  if (white_bit) begin
                     accum_in = accum_in | mask_in;
                  end
                  // rejection: restart from the top bit once the prefix reaches span
                  if (accum_in >= cfg.span) begin
                     accum_in = '0;
                     mask_in  = cfg.top;
                  end else begin
                     mask_in = mask_in >> 1;
                     if (mask_in == '0) begin
                        res_valid = 1'b1;
                        res_value = cfg.low + accum_in;
                        done      = 1'b1;
                     end
                  end
               end else begin
                  accum_in = {1'b0, accum_in[VALUE_BITS-3:0], white_bit};
                  left_in  = left_in - LEFT_BITS'(1);
                  if (left_in == '0) begin
                     res_valid = 1'b1;
                     res_value = accum_in;
                     done      = 1'b1;
                  end
               end
            end
         end
      end
      if (done || cfg_abort) begin
         accum_in   = '0;
         mask_in    = '0;
         left_in    = '0;
         started_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff   <= '0;
         mask_ff    <= '0;
         left_ff    <= '0;
         started_ff <= 1'b0;
      end else begin
         accum_ff   <= accum_in;
         mask_ff    <= mask_in;
         left_ff    <= left_in;
         started_ff <= started_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_byte_width: assert property (@(posedge clock) disable iff (reset)
      res_valid && (cfg.mode == MODE_BYTE) && !bypass |-> res_value[VALUE_BITS-1:8] == '0)
      else $error("byte mode word wider than 8 bits");

   a_w15_width: assert property (@(posedge clock) disable iff (reset)
      res_valid && (cfg.mode == MODE_W15) |-> res_value[VALUE_BITS-1:15] == '0)
      else $error("15-bit mode word too wide");

   a_range_bound: assert property (@(posedge clock) disable iff (reset)
      res_valid && (cfg.mode == MODE_RANGE) && !cfg.span_le1
      |-> (res_value - cfg.low) < cfg.span)
      else $error("range word outside bounds");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (accum_ff == '0) && (mask_ff == '0) && (left_ff == '0))
      else $error("builder state left over after completion");
`endif

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for whitened_random_range_generator_top
// predicts each random value from the accepted samples and checks the rsp stream
// depends on wrrg_pkg and the rtl of the block
module tb_top;
   import wrrg_pkg::*;

   localparam logic [INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;  // [11:0] adc_sample, [15:12] zero
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;  // [31:0] rand_value
   logic csr_wen = 1'b0;
   logic [INDEX_BITS-1:0] csr_index = '0;
   logic [VALUE_BITS-1:0] csr_wdata = '0;

   whitened_random_range_generator_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor copy of the registers and the extractor state
   out_mode_type cfg_mode = MODE_BYTE;
   logic [31:0] cfg_low = '0;
   logic [31:0] cfg_high = '0;
   logic pend_bit [2] = '{1'b0, 1'b0};
   logic pend_have [2] = '{1'b0, 1'b0};
   logic [31:0] build_acc = '0;
   logic [31:0] build_mask = '0;
   logic [4:0] build_left = '0;
   logic build_busy = 1'b0;

   logic [31:0] expected_values [$];
   logic [31:0] expected_word;
   int send_idle = 0;
   int recv_stall = 0;
   int fail_count = 0;
   int idle_cycles = 0;
   int setting_items = 0;
   int setting_results = 0;

   function automatic logic [31:0] top_mask(input logic [31:0] span);
      logic [31:0] t;
      logic [31:0] m;
      t = span - 32'd1;
      m = 32'h8000_0000;
      while (m != 0 && (t & m) == 0) m = m >> 1;
      return m;
   endfunction

   // one von neumann stage; returns {emitted, bit}
   function automatic logic [1:0] pair_stage(input int st, input logic b);
      if (!pend_have[st]) begin
         pend_bit[st] = b;
         pend_have[st] = 1'b1;
         return 2'b00;
      end
      pend_have[st] = 1'b0;
      if (pend_bit[st] == b) return 2'b00;
      return {1'b1, b};
   endfunction

   function automatic void clear_value();
      build_acc = '0;
      build_mask = '0;
      build_left = '0;
      build_busy = 1'b0;
   endfunction

   function automatic void post_value(input logic [31:0] v);
      expected_values.push_back(v);
      setting_results++;
   endfunction

   function automatic void predict_value(input logic [11:0] sample);
      logic [31:0] span;
      logic [1:0] s1;
      logic [1:0] s2;
      span = (cfg_high > cfg_low) ? cfg_high - cfg_low : 32'd0;
      if (!build_busy) begin
         // span needs no bits: answer at once, sample is dropped
         if (cfg_mode == MODE_RANGE && span <= 32'd1) begin
            post_value(cfg_low);
            return;
         end
         clear_value();
         build_busy = 1'b1;
         case (cfg_mode)
            MODE_BYTE: build_left = LEFT_BYTE;
            MODE_W15:  build_left = LEFT_W15;
            MODE_W31:  build_left = LEFT_W31;
            default:   build_mask = top_mask(span);
         endcase
      end
      s1 = pair_stage(0, sample[0]);
      if (!s1[1]) return;
      s2 = pair_stage(1, s1[0]);
      if (!s2[1]) return;
      if (cfg_mode == MODE_RANGE) begin
         if (s2[0]) build_acc = build_acc | build_mask;
         // partial value reached the span: start over from the top bit
         if (build_acc >= span) begin
            build_acc = '0;
            build_mask = top_mask(span);
            return;
         end
         build_mask = build_mask >> 1;
         if (build_mask != 0) return;
         post_value(cfg_low + build_acc);
      end else begin
         build_acc = {1'b0, build_acc[29:0], s2[0]};
         build_left = build_left - 5'd1;
         if (build_left != 0) return;
         post_value(build_acc);
      end
      clear_value();
   endfunction

   task automatic send_sample(input logic [11:0] sample);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, sample};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_value(sample);
      setting_items++;
   endtask

   // four samples that whiten to one bit when both stages are aligned
   task automatic send_bit(input logic b);
      logic [11:0] r;
      // finish any half pair first so the group lines up with both stages
      if (pend_have[0]) begin
         r = 12'($urandom);
         send_sample(r);
      end
      if (pend_have[1]) begin
         r = 12'($urandom);
         send_sample({r[11:1], 1'b0});
         send_sample({r[11:1], 1'b1});
      end
      r = 12'($urandom);
      send_sample({r[11:1], b});
      r = 12'($urandom);
      send_sample({r[11:1], ~b});
      r = 12'($urandom);
      send_sample({r[11:1], ~b});
      r = 12'($urandom);
      send_sample({r[11:1], b});
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [INDEX_BITS-1:0] index, input logic [31:0] data);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_OUT_MODE: begin
            cfg_mode = out_mode_type'(data[1:0]);
            clear_value();
         end
         CSR_RANGE_LOW: begin
            cfg_low = data;
            clear_value();
         end
         CSR_RANGE_HIGH: begin
            cfg_high = data;
            clear_value();
         end
         default: ;
      endcase
   endtask

   task automatic apply_setting(input out_mode_type mode, input logic [31:0] low,
                                input logic [31:0] high);
      logic [31:0] r;
      r = $urandom;
      settle();
      write_csr(CSR_OUT_MODE, {r[31:2], mode});
      write_csr(CSR_RANGE_LOW, low);
      write_csr(CSR_RANGE_HIGH, high);
   endtask

   // mostly aligned bit groups, some raw noise, and one write midway to the unused index or of an unchanged range_high
   task automatic feed_setting();
      logic [11:0] noise;
      bit disturbed;
      disturbed = 1'b0;
      setting_items = 0;
      setting_results = 0;
      while (setting_items < 50 || setting_results == 0) begin
         if (!disturbed && setting_items >= 25) begin
            disturbed = 1'b1;
            settle();
            if ($urandom_range(1)) write_csr(CSR_UNUSED, $urandom);
            else write_csr(CSR_RANGE_HIGH, cfg_high);
         end
         if ($urandom_range(9) < 8) send_bit(1'($urandom_range(1)));
         else begin
            noise = 12'($urandom);
            send_sample(noise);
         end
      end
   endtask

   task automatic test_empty_span();
      apply_setting(MODE_RANGE, 32'd5, 32'd5);
      send_sample(12'h000);
      send_sample(12'hfff);
      apply_setting(MODE_RANGE, 32'hffff_ffff, 32'h0000_0000);
      send_sample(12'h001);
      send_sample(12'hffe);
      apply_setting(MODE_RANGE, 32'hffff_fffe, 32'hffff_ffff);
      send_sample(12'h555);
      send_sample(12'haaa);
   endtask

   task automatic test_sample_bits();
      apply_setting(MODE_BYTE, 32'h0, 32'h0);
      send_sample(12'h000);
      send_sample(12'hfff);
      send_sample(12'h001);
      send_sample(12'hffe);
      send_sample(12'h800);
      send_sample(12'h7ff);
      send_sample(12'h001);
      send_sample(12'h000);
      send_sample(12'hfff);
      send_sample(12'h001);
   endtask

   task automatic test_modes_under_load(input int idle_pct, input int stall_pct);
      logic [31:0] low;
      send_idle = idle_pct;
      recv_stall = stall_pct;
      for (int k = 0; k < 6; k++) begin
         low = $urandom;
         case (k)
            0: apply_setting(MODE_BYTE, low, $urandom);
            1: apply_setting(MODE_W15, low, $urandom);
            2: apply_setting(MODE_W31, low, $urandom);
            3: apply_setting(MODE_RANGE, 32'h0, 32'hffff_ffff);
            4: apply_setting(MODE_RANGE, low, low + 32'd2);
            default: apply_setting(out_mode_type'($urandom_range(3)), low,
                                   low + $urandom_range(600));
         endcase
         feed_setting();
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_values.size() == 0) begin
            $error("rand_value: expected none, actual %h", rsp_tdata);
            fail_count++;
         end else begin
            expected_word = expected_values.pop_front();
            if (rsp_tdata !== expected_word) begin
               $error("rand_value: expected %h, actual %h", expected_word, rsp_tdata);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_span();
      test_sample_bits();
      test_modes_under_load(0, 0);
      test_modes_under_load(82, 0);
      test_modes_under_load(0, 82);
      test_modes_under_load(28, 28);
      settle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
